// ===== hw/rtl/sbi_pkg.sv =====
`timescale 1ns / 1ps
// Package for the segment / box intersection block.
// Holds configuration register indexes, field widths and default parameters.
package sbi_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int TOL_BITS   = 31;
  localparam int EPS_BITS   = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SEG_MODE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EPSILON   = 2'd2;

  // Working width of differences, magnitudes and widened extents.
  function automatic int ext_width(input int w);
    return ((w > TOL_BITS) ? w : TOL_BITS) + 3;
  endfunction

  typedef struct packed {
    logic valid;
    logic apart;
    logic enclosed;
  } sbi_ctrl_t;

endpackage

// ===== hw/rtl/segment_box_intersect.sv =====
`timescale 1ns / 1ps
// Segment / axis-aligned box intersection test, six register stages deep.
// A request passes stages A and B in sbi_prep, C to E in sbi_face, then the out_valid/out_hit register.
// Throughput is one request per cycle; busy stays low, so start is always taken.
// Synchronous active-low reset clears the valid bits and loads the register defaults.
// The receiver cannot stall; each result is shown for exactly one cycle.
module segment_box_intersect #(
  parameter int COORD_BITS = sbi_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sbi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_BITS-1:0]      in_start_x,
  input  logic signed [COORD_BITS-1:0]      in_start_y,
  input  logic signed [COORD_BITS-1:0]      in_start_z,
  input  logic signed [COORD_BITS-1:0]      in_end_x,
  input  logic signed [COORD_BITS-1:0]      in_end_y,
  input  logic signed [COORD_BITS-1:0]      in_end_z,
  input  logic signed [COORD_BITS-1:0]      in_box_min_x,
  input  logic signed [COORD_BITS-1:0]      in_box_min_y,
  input  logic signed [COORD_BITS-1:0]      in_box_min_z,
  input  logic signed [COORD_BITS-1:0]      in_box_max_x,
  input  logic signed [COORD_BITS-1:0]      in_box_max_y,
  input  logic signed [COORD_BITS-1:0]      in_box_max_z,
  output logic                              out_valid,
  output logic                              out_hit,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [sbi_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import sbi_pkg::*;

  localparam int EW = ext_width(COORD_BITS);

  logic                seg_mode_r;
  logic [TOL_BITS-1:0] tolerance_r;
  logic [EPS_BITS-1:0] epsilon_r;
  logic signed [EW-1:0] tol_x, eps_x;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_mode_r  <= 1'b1;
      tolerance_r <= '0;
      epsilon_r   <= EPS_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEG_MODE:  seg_mode_r  <= cfg_data[0];
        CFG_TOLERANCE: tolerance_r <= cfg_data[TOL_BITS-1:0];
        CFG_EPSILON:   epsilon_r   <= cfg_data[EPS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign tol_x = EW'(tolerance_r);
  assign eps_x = EW'(epsilon_r);

  logic signed [COORD_BITS-1:0] p [3], q [3], mn [3], mx [3];

  assign p  = '{in_start_x, in_start_y, in_start_z};
  assign q  = '{in_end_x, in_end_y, in_end_z};
  assign mn = '{in_box_min_x, in_box_min_y, in_box_min_z};
  assign mx = '{in_box_max_x, in_box_max_y, in_box_max_z};

  logic signed [EW-1:0] ad [3], dir [3], pm [3], nlo [3], nhi [3], exttol [3];
  logic [2:0]           act;
  sbi_ctrl_t            ctrl_b;
  logic [2:0]           axis_hit;

  sbi_prep #(.COORD_BITS(COORD_BITS), .EW(EW)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .p        (p),
    .q        (q),
    .mn       (mn),
    .mx       (mx),
    .tol      (tol_x),
    .eps      (eps_x),
    .ad_r     (ad),
    .dir_r    (dir),
    .pm_r     (pm),
    .nlo_r    (nlo),
    .nhi_r    (nhi),
    .exttol_r (exttol),
    .act_r    (act),
    .ctrl_r   (ctrl_b)
  );

  for (genvar g = 0; g < 3; g++) begin : g_axis
    sbi_face #(.AX(g), .FRAC_BITS(FRAC_BITS), .EW(EW)) u_face (
      .clk        (clk),
      .seg        (seg_mode_r),
      .tol        (tol_x),
      .eps        (eps_x),
      .ad         (ad),
      .dir        (dir),
      .pm         (pm),
      .nlo        (nlo),
      .nhi        (nhi),
      .exttol     (exttol),
      .act        (act),
      .axis_hit_r (axis_hit[g])
    );
  end

  // Prefilter flags ride alongside the three face stages.
  sbi_ctrl_t ctrl_c_r, ctrl_d_r, ctrl_e_r;
  logic      out_valid_r, out_hit_r;
  logic      hit_nxt;

  always_comb begin
    if (seg_mode_r && ctrl_e_r.apart) begin
      hit_nxt = 1'b0;
    end else if (seg_mode_r && ctrl_e_r.enclosed) begin
      hit_nxt = 1'b1;
    end else begin
      hit_nxt = |axis_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_c_r    <= '0;
      ctrl_d_r    <= '0;
      ctrl_e_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctrl_c_r    <= ctrl_b;
      ctrl_d_r    <= ctrl_c_r;
      ctrl_e_r    <= ctrl_d_r;
      out_valid_r <= ctrl_e_r.valid;
    end
    out_hit_r <= hit_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

// ===== hw/rtl/sbi_prep.sv =====
`timescale 1ns / 1ps
// Front stages: differences, direction magnitudes and the bounding box prefilters.
// Depends on sbi_pkg.
module sbi_prep #(
  parameter int COORD_BITS = 32,
  parameter int EW         = 35
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [COORD_BITS-1:0]  p   [3],
  input  logic signed [COORD_BITS-1:0]  q   [3],
  input  logic signed [COORD_BITS-1:0]  mn  [3],
  input  logic signed [COORD_BITS-1:0]  mx  [3],
  input  logic signed [EW-1:0]          tol,
  input  logic signed [EW-1:0]          eps,
  output logic signed [EW-1:0]          ad_r     [3],
  output logic signed [EW-1:0]          dir_r    [3],
  output logic signed [EW-1:0]          pm_r     [3],
  output logic signed [EW-1:0]          nlo_r    [3],
  output logic signed [EW-1:0]          nhi_r    [3],
  output logic signed [EW-1:0]          exttol_r [3],
  output logic [2:0]                    act_r,
  output sbi_pkg::sbi_ctrl_t            ctrl_r
);
  import sbi_pkg::*;

  // Stage A registers.
  logic signed [EW-1:0] a_dir_r [3];
  logic signed [EW-1:0] a_ext_r [3];
  logic signed [EW-1:0] a_pm_r  [3];
  logic signed [EW-1:0] a_nlo_r [3];
  logic signed [EW-1:0] a_nhi_r [3];
  logic signed [EW-1:0] a_mn_r  [3];
  logic signed [EW-1:0] a_mx_r  [3];
  logic signed [EW-1:0] a_smin_r [3];
  logic signed [EW-1:0] a_smax_r [3];
  logic                 a_valid_r;

  logic signed [EW-1:0] a_dir_nxt [3];
  logic signed [EW-1:0] a_ext_nxt [3];
  logic signed [EW-1:0] a_pm_nxt  [3];
  logic signed [EW-1:0] a_nlo_nxt [3];
  logic signed [EW-1:0] a_nhi_nxt [3];
  logic signed [EW-1:0] a_mn_nxt  [3];
  logic signed [EW-1:0] a_mx_nxt  [3];
  logic signed [EW-1:0] a_smin_nxt [3];
  logic signed [EW-1:0] a_smax_nxt [3];

  logic signed [EW-1:0] ad_nxt     [3];
  logic signed [EW-1:0] nlo_nxt    [3];
  logic signed [EW-1:0] nhi_nxt    [3];
  logic signed [EW-1:0] exttol_nxt [3];
  logic [2:0]           act_nxt;
  logic [2:0]           apart_ax;
  logic [2:0]           inside_ax;
  sbi_ctrl_t            ctrl_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_dir_nxt[k] = EW'(q[k]) - EW'(p[k]);
      a_ext_nxt[k] = EW'(mx[k]) - EW'(mn[k]);
      a_pm_nxt[k]  = EW'(p[k]) - EW'(mn[k]);
      a_nlo_nxt[k] = EW'(mn[k]) - EW'(p[k]);
      a_nhi_nxt[k] = EW'(mx[k]) - EW'(p[k]);
      a_mn_nxt[k]  = EW'(mn[k]);
      a_mx_nxt[k]  = EW'(mx[k]);
      a_smin_nxt[k] = (p[k] < q[k]) ? EW'(p[k]) : EW'(q[k]);
      a_smax_nxt[k] = (p[k] < q[k]) ? EW'(q[k]) : EW'(p[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
    end
    for (int k = 0; k < 3; k++) begin
      a_dir_r[k]  <= a_dir_nxt[k];
      a_ext_r[k]  <= a_ext_nxt[k];
      a_pm_r[k]   <= a_pm_nxt[k];
      a_nlo_r[k]  <= a_nlo_nxt[k];
      a_nhi_r[k]  <= a_nhi_nxt[k];
      a_mn_r[k]   <= a_mn_nxt[k];
      a_mx_r[k]   <= a_mx_nxt[k];
      a_smin_r[k] <= a_smin_nxt[k];
      a_smax_r[k] <= a_smax_nxt[k];
    end
  end

  // Stage B: fold direction sign into plane distances, widen extents, set flags.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ad_nxt[k]     = a_dir_r[k][EW-1] ? -a_dir_r[k] : a_dir_r[k];
      nlo_nxt[k]    = a_dir_r[k][EW-1] ? -a_nlo_r[k] : a_nlo_r[k];
      nhi_nxt[k]    = a_dir_r[k][EW-1] ? -a_nhi_r[k] : a_nhi_r[k];
      exttol_nxt[k] = a_ext_r[k] + tol;
      act_nxt[k]    = (a_dir_r[k] > eps) || (a_dir_r[k] < -eps);
      apart_ax[k]   = (a_mn_r[k] > a_smax_r[k] + tol) || (a_smin_r[k] > a_mx_r[k] + tol);
      inside_ax[k]  = !((a_mn_r[k] > a_smin_r[k] + tol) || (a_smax_r[k] > a_mx_r[k] + tol));
    end
    ctrl_nxt.valid    = a_valid_r;
    ctrl_nxt.apart    = |apart_ax;
    ctrl_nxt.enclosed = &inside_ax;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
    for (int k = 0; k < 3; k++) begin
      ad_r[k]     <= ad_nxt[k];
      dir_r[k]    <= a_dir_r[k];
      pm_r[k]     <= a_pm_r[k];
      nlo_r[k]    <= nlo_nxt[k];
      nhi_r[k]    <= nhi_nxt[k];
      exttol_r[k] <= exttol_nxt[k];
    end
    act_r <= act_nxt;
  end

endmodule

// ===== hw/rtl/sbi_face.sv =====
`timescale 1ns / 1ps
// Face pair test for one axis: products, sums and exact compares over three stages.
// Depends on sbi_pkg.
module sbi_face #(
  parameter int AX        = 0,
  parameter int FRAC_BITS = 16,
  parameter int EW        = 35
) (
  input  logic                 clk,
  input  logic                 seg,
  input  logic signed [EW-1:0] tol,
  input  logic signed [EW-1:0] eps,
  input  logic signed [EW-1:0] ad     [3],
  input  logic signed [EW-1:0] dir    [3],
  input  logic signed [EW-1:0] pm     [3],
  input  logic signed [EW-1:0] nlo    [3],
  input  logic signed [EW-1:0] nhi    [3],
  input  logic signed [EW-1:0] exttol [3],
  input  logic [2:0]           act,
  output logic                 axis_hit_r
);
  import sbi_pkg::*;

  localparam int I1 = (AX == 0) ? 1 : 0;
  localparam int I2 = (AX == 2) ? 1 : 2;
  localparam int MW = 2 * EW;
  localparam int PW = 2 * EW + 1;

  // Stage C: products.
  logic signed [MW-1:0] tad_r, ead_r;
  logic signed [MW-1:0] pad_r [2];
  logic signed [MW-1:0] uad_r [2];
  logic signed [MW-1:0] nld_r [2];
  logic signed [MW-1:0] nhd_r [2];
  logic signed [EW-1:0] c_nlo_r, c_nhi_r, c_ad_r;
  logic                 c_act_r;

  always_ff @(posedge clk) begin
    tad_r    <= tol * ad[AX];
    ead_r    <= eps * ad[AX];
    pad_r[0] <= pm[I1] * ad[AX];
    pad_r[1] <= pm[I2] * ad[AX];
    uad_r[0] <= exttol[I1] * ad[AX];
    uad_r[1] <= exttol[I2] * ad[AX];
    nld_r[0] <= nlo[AX] * dir[I1];
    nld_r[1] <= nlo[AX] * dir[I2];
    nhd_r[0] <= nhi[AX] * dir[I1];
    nhd_r[1] <= nhi[AX] * dir[I2];
    c_nlo_r  <= nlo[AX];
    c_nhi_r  <= nhi[AX];
    c_ad_r   <= ad[AX];
    c_act_r  <= act[AX];
  end

  // Stage D: crossing offsets and bounds.
  logic signed [PW-1:0] xl_r [2];
  logic signed [PW-1:0] xh_r [2];
  logic signed [PW-1:0] ub_r [2];
  logic signed [PW-1:0] lb_r, plo_r, phi_r, lhsl_r, lhsh_r;
  logic                 d_act_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      xl_r[k] <= PW'(pad_r[k]) + PW'(nld_r[k]);
      xh_r[k] <= PW'(pad_r[k]) + PW'(nhd_r[k]);
      ub_r[k] <= PW'(uad_r[k]);
    end
    lb_r    <= -PW'(tad_r);
    plo_r   <= -PW'(ead_r);
    phi_r   <= (PW'(c_ad_r) <<< FRAC_BITS) + PW'(ead_r);
    lhsl_r  <= PW'(c_nlo_r) <<< FRAC_BITS;
    lhsh_r  <= PW'(c_nhi_r) <<< FRAC_BITS;
    d_act_r <= c_act_r;
  end

  // Stage E: strict compares; the parameter window applies in segment mode only.
  logic face_lo, face_hi;

  always_comb begin
    face_lo = !seg || ((plo_r < lhsl_r) && (lhsl_r < phi_r));
    face_hi = !seg || ((plo_r < lhsh_r) && (lhsh_r < phi_r));
    for (int k = 0; k < 2; k++) begin
      face_lo = face_lo && (lb_r < xl_r[k]) && (xl_r[k] < ub_r[k]);
      face_hi = face_hi && (lb_r < xh_r[k]) && (xh_r[k] < ub_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    axis_hit_r <= d_act_r && (face_lo || face_hi);
  end

endmodule

// ===== hw/rtl/sbi_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the intersection block, attached by bind.
// Depends only on the top level's ports.
module sbi_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_valid,
  input logic cfg_ready
);

  // Every result traces back to a request accepted earlier.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> $past(start, 6))
    else $error("result without a matching request");

  // A request taken in a cycle with no reset around it yields a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(start, 6) && $past(rst_n, 6) && $past(rst_n, 5) && $past(rst_n, 4)
     && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)) |-> out_valid)
    else $error("request lost in the pipeline");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  assert property (@(posedge clk) disable iff (!rst_n) !busy && (!cfg_valid || cfg_ready))
    else $error("block refused a request or a register write");

endmodule

bind segment_box_intersect sbi_checker u_sbi_checker (.*);

// ===== dv/sbi_checker.sv =====
`timescale 1ns / 1ps
// Checker for the segment / box intersection block: tracks register writes,
// predicts the hit flag of each accepted request and compares it. Needs sbi_pkg.
module tb_sbi_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [31:0]                coord [12],
  input  logic                              out_valid,
  input  logic                              out_hit,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [sbi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [sbi_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                fail_count,
  output int                                pending
);
  import sbi_pkg::*;

  typedef logic signed [127:0] wide_t;
  localparam longint ONE = longint'(1) << 16;

  logic                seg_mode;
  logic [TOL_BITS-1:0] tol_reg;
  logic [EPS_BITS-1:0] eps_reg;
  bit                  hit_queue[$];

  assign pending = hit_queue.size();

  // Exact face test: every comparison is scaled by the direction magnitude.
  function automatic bit face_crossing(longint p[3], longint dir[3], longint mn[3],
                                       longint ext[3], int ax, longint plane, int a1,
                                       int a2, longint tol, longint eps, bit seg);
    longint d, ad, n;
    wide_t  lhs, lo, hi, x;
    int     a;
    d  = dir[ax];
    ad = (d < 0) ? -d : d;
    n  = plane - p[ax];
    if (d < 0) n = -n;
    if (seg) begin
      lhs = wide_t'(n) * wide_t'(ONE);
      lo  = -(wide_t'(eps) * wide_t'(ad));
      hi  = wide_t'(ONE + eps) * wide_t'(ad);
      if (!(lo < lhs && lhs < hi)) return 0;
    end
    for (int k = 0; k < 2; k++) begin
      a = (k == 0) ? a1 : a2;
      x = wide_t'(p[a] - mn[a]) * wide_t'(ad) + wide_t'(n) * wide_t'(dir[a]);
      if (!(-(wide_t'(tol) * wide_t'(ad)) < x)) return 0;
      if (!(x < wide_t'(ext[a] + tol) * wide_t'(ad))) return 0;
    end
    return 1;
  endfunction

  function automatic bit predict_hit(logic signed [31:0] c[12], bit seg, longint tol,
                                     longint eps);
    longint p[3], q[3], mn[3], mx[3], dir[3], ext[3], smin[3], smax[3];
    bit     apart, contained;
    int     o1, o2;
    apart = 0;
    contained = 1;
    for (int i = 0; i < 3; i++) begin
      p[i]    = c[i];
      q[i]    = c[3+i];
      mn[i]   = c[6+i];
      mx[i]   = c[9+i];
      dir[i]  = q[i] - p[i];
      ext[i]  = mx[i] - mn[i];
      smin[i] = (p[i] < q[i]) ? p[i] : q[i];
      smax[i] = (p[i] < q[i]) ? q[i] : p[i];
      if (mn[i] > smax[i] + tol || smin[i] > mx[i] + tol) apart = 1;
      if (mn[i] > smin[i] + tol || smax[i] > mx[i] + tol) contained = 0;
    end
    if (seg && apart) return 0;
    if (seg && contained) return 1;
    for (int ax = 0; ax < 3; ax++) begin
      if (!(dir[ax] > eps || dir[ax] < -eps)) continue;
      o1 = (ax == 0) ? 1 : 0;
      o2 = (ax == 2) ? 1 : 2;
      if (face_crossing(p, dir, mn, ext, ax, mn[ax], o1, o2, tol, eps, seg) ||
          face_crossing(p, dir, mn, ext, ax, mx[ax], o1, o2, tol, eps, seg))
        return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    bit want;
    if (!rst_n) begin
      seg_mode <= 1'b1;
      tol_reg  <= '0;
      eps_reg  <= 16'd1;
      hit_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SEG_MODE:  seg_mode <= cfg_data[0];
          CFG_TOLERANCE: tol_reg  <= cfg_data[TOL_BITS-1:0];
          CFG_EPSILON:   eps_reg  <= cfg_data[EPS_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (hit_queue.size() == 0) begin
          $error("result with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = hit_queue.pop_front();
          if (out_hit !== want) begin
            $error("hit: expected %0d, actual %0d", want, out_hit);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        hit_queue.insert(hit_queue.size(), predict_hit(coord, seg_mode, longint'(tol_reg),
                                                       longint'(eps_reg)));
    end
  end
endmodule

// ===== dv/tb_segment_box_intersect.sv =====
`timescale 1ns / 1ps
// Top of the segment / box intersection testbench: clock, reset, stimulus, verdict.
// Depends on sbi_pkg, segment_box_intersect and tb_sbi_checker.
module tb_segment_box_intersect;
  import sbi_pkg::*;

  localparam int RAND_PER_PHASE = 280;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [31:0] coord [12];
  logic out_valid, out_hit;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  int fail_count, pending;
  bit idle_en;

  initial for (int i = 0; i < 12; i++) coord[i] = '0;

  always #4 clk = ~clk;

  segment_box_intersect DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(coord[0]), .in_start_y(coord[1]), .in_start_z(coord[2]),
    .in_end_x(coord[3]), .in_end_y(coord[4]), .in_end_z(coord[5]),
    .in_box_min_x(coord[6]), .in_box_min_y(coord[7]), .in_box_min_z(coord[8]),
    .in_box_max_x(coord[9]), .in_box_max_y(coord[10]), .in_box_max_z(coord[11]),
    .out_valid(out_valid), .out_hit(out_hit),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  tb_sbi_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .coord(coord),
    .out_valid(out_valid), .out_hit(out_hit), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Drives one request and returns after the edge that accepts it.
  task automatic send_request(logic signed [31:0] c[12]);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start <= 1'b1;
    for (int i = 0; i < 12; i++) coord[i] <= c[i];
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
  endtask

  task automatic set_mode(bit seg, logic [31:0] tol, logic [31:0] eps);
    drain();
    write_reg(CFG_SEG_MODE, {$urandom_range(0, 1) ? 31'h7fffffff : 31'h0, seg});
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_EPSILON, eps);
    cfg_valid <= 1'b0;
  endtask

  function automatic longint spread(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  // Mostly segments near a box, plus noise, degenerate segments and inverted boxes.
  task automatic random_request();
    logic signed [31:0] c[12];
    longint ctr, half, lim;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      for (int i = 0; i < 12; i++) c[i] = $urandom;
    end else begin
      lim = $urandom_range(0, 3) == 0 ? (1 << 30) : (1 << 20);
      for (int a = 0; a < 3; a++) begin
        ctr  = spread(lim);
        half = $urandom_range(0, 32'(lim / 4));
        c[6+a] = 32'(ctr - half);
        c[9+a] = 32'(ctr + half);
        c[a]   = 32'(ctr + spread(2 * half + 2));
        c[3+a] = (kind == 8) ? 32'(c[a] + spread(2)) : 32'(ctr + spread(2 * half + 2));
      end
      if (kind == 9) begin
        c[12 - 3 - $urandom_range(1, 3) + 3] = c[6];
        c[6] = c[9] + 5;
      end
    end
    send_request(c);
  endtask

  task automatic directed_request(longint s0, s1, s2, e0, e1, e2,
                                  m0, m1, m2, x0, x1, x2);
    logic signed [31:0] c[12];
    c = '{32'(s0), 32'(s1), 32'(s2), 32'(e0), 32'(e1), 32'(e2),
          32'(m0), 32'(m1), 32'(m2), 32'(x0), 32'(x1), 32'(x2)};
    send_request(c);
  endtask

  task automatic directed_set();
    longint mx, mn, u;
    mx = 64'sh7fffffff;
    mn = -64'sh80000000;
    u  = 64'sh10000;
    directed_request(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx);
    directed_request(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn);
    directed_request(mn, mn, mn, mx, mx, mx, mn, mn, mn, mx, mx, mx);
    directed_request(mx, mn, mx, mn, mx, mn, 0, 0, 0, u, u, u);
    directed_request(mn, mn, mn, mx, mx, mx, -u, -u, -u, u, u, u);
    // Crossing along each axis, touching a face, inside, apart.
    directed_request(-4*u, 0, 0, 4*u, 0, 0, -u, -u, -u, u, u, u);
    directed_request(0, -4*u, 0, 0, 4*u, 0, -u, -u, -u, u, u, u);
    directed_request(0, 0, -4*u, 0, 0, 4*u, -u, -u, -u, u, u, u);
    directed_request(-4*u, u, 0, 4*u, u, 0, -u, -u, -u, u, u, u);
    directed_request(0, 0, 0, u/2, u/2, u/2, -u, -u, -u, u, u, u);
    directed_request(5*u, 5*u, 5*u, 6*u, 7*u, 8*u, -u, -u, -u, u, u, u);
    directed_request(-4*u, -3*u, 0, -2*u, -u/2, 0, -u, -u, -u, u, u, u);
    // Degenerate segment, both outside and inside.
    directed_request(3*u, 0, 0, 3*u, 0, 0, -u, -u, -u, u, u, u);
    directed_request(0, 0, 0, 1, 0, 1, -u, -u, -u, u, u, u);
    // Inverted boxes, then a segment apart from a normal box.
    directed_request(-4*u, 0, 0, 4*u, 0, 0, u, -u, -u, -u, u, u);
    directed_request(0, -4*u, 0, 0, 4*u, 0, -u, u, u, u, -u, -u);
    directed_request(2*u, 2*u, 2*u, 3*u, -3*u, 3*u, -u, -u, -u, u, u, u);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) random_request();
  endtask

  initial begin
    idle_en = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_set();
    random_phase(RAND_PER_PHASE);
    set_mode(0, 32'h0, 32'h0);
    directed_set();
    random_phase(RAND_PER_PHASE);
    set_mode(1, 32'hffffffff, 32'hffffffff);
    directed_set();
    random_phase(RAND_PER_PHASE / 2);
    set_mode(1, $urandom_range(0, 32'h30000), $urandom_range(0, 32'h2000));
    random_phase(RAND_PER_PHASE);
    set_mode(0, $urandom_range(0, 32'h30000), $urandom_range(0, 32'hffff));
    random_phase(RAND_PER_PHASE);
    set_mode(1, $urandom_range(0, 32'h800), $urandom_range(0, 32'h40));
    random_phase(RAND_PER_PHASE / 2);
    idle_en = 0;
    random_phase(100);
    drain();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
